// ===== sv/dq_pkg.sv =====
// Shared definitions for the double-ended queue: operation and status codes,
// default sizes and the control group that the top level sends to every cell.
// No dependencies.
package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH_FRONT = 2'd0;
  localparam op_t OP_PUSH_BACK  = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_BACK   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // One-cycle strobes for the row of cells; at most one is high at a time.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
  } cell_ctrl_t;

endpackage

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue built as a row of DEPTH shifting cells.
// Depends on dq_pkg and dq_cell.
//
// Each request (push front, push back, pop front, pop back) acts in the cycle
// the transaction is accepted: the row of cells shifts or loads as the request
// needs, and its result appears in the output register on the next cycle.
// A new request is accepted every cycle while the output register is empty or
// its transaction is being taken, so the sustained rate is one per cycle and
// is set by the single output register. A push into a full queue returns a
// full status and a pop from an empty one returns zero with an empty status;
// every result carries the entry count after the request. Entries that were
// never written hold no defined value.
module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  dq_pkg::op_t            in_operation,
  input  logic [DATA_WIDTH-1:0]  in_push_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_WIDTH-1:0]  out_pop_value,
  output dq_pkg::status_t        out_status,
  output logic [CW-1:0]          out_item_count
);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_pop_value_r;
  logic [DATA_WIDTH-1:0] out_pop_value_nxt;
  dq_pkg::status_t       out_status_r;
  dq_pkg::status_t       out_status_nxt;

  logic                  accept;
  logic                  is_push;
  logic                  full;
  logic                  empty;
  dq_pkg::cell_ctrl_t    ctrl;
  logic [DATA_WIDTH-1:0] cell_q    [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
  logic [DATA_WIDTH-1:0] back_value;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_push  = (in_operation == dq_pkg::OP_PUSH_FRONT) ||
                    (in_operation == dq_pkg::OP_PUSH_BACK);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    ctrl.push_front = accept && !full  && (in_operation == dq_pkg::OP_PUSH_FRONT);
    ctrl.push_back  = accept && !full  && (in_operation == dq_pkg::OP_PUSH_BACK);
    ctrl.pop_front  = accept && !empty && (in_operation == dq_pkg::OP_POP_FRONT);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = in_push_value;
    end else begin : g_mid_l
      assign left_data = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_q[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .push_value (in_push_value),
      .from_left  (left_data),
      .from_right (right_data),
      .data_q     (cell_q[i]),
      .tail_data  (cell_tail[i])
    );
  end

  // Only the back cell presents its data, so an OR gathers the back entry.
  always_comb begin
    back_value = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      back_value = back_value | cell_tail[i];
    end
  end

  always_comb begin
    count_nxt         = count_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_pop_value_nxt = out_pop_value_r;
    out_status_nxt    = out_status_r;
    if (accept) begin
      out_valid_nxt     = 1'b1;
      out_pop_value_nxt = '0;
      out_status_nxt    = dq_pkg::ST_DONE;
      if (is_push) begin
        if (full) begin
          out_status_nxt = dq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          out_status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt         = count_r - CW'(1);
          out_pop_value_nxt = (in_operation == dq_pkg::OP_POP_FRONT) ? cell_q[0] : back_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pop_value  = out_pop_value_r;
  assign out_status     = out_status_r;
  assign out_item_count = count_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_full_refused : assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_push && full |=> out_status_r == dq_pkg::ST_FULL && count_r == $past(count_r))
    else $error("push into a full queue was not refused");

  a_pop_counts : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_push && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("successful pop did not decrement the count");

  a_empty_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == dq_pkg::ST_EMPTY |-> out_pop_value_r == '0)
    else $error("refused pop returned a non-zero word");

endmodule

// ===== sv/dq_cell.sv =====
// One storage cell of the queue row. Cell IDX holds the entry at distance IDX
// from the front. Depends on dq_pkg.
module dq_cell #(
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CW         = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                   clk,
  input  dq_pkg::cell_ctrl_t     ctrl,
  input  logic [CW-1:0]          count,
  input  logic [DATA_WIDTH-1:0]  push_value,
  input  logic [DATA_WIDTH-1:0]  from_left,
  input  logic [DATA_WIDTH-1:0]  from_right,
  output logic [DATA_WIDTH-1:0]  data_q,
  output logic [DATA_WIDTH-1:0]  tail_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  is_free_slot;
  logic                  is_tail;

  // The first free cell sits at the count; the back entry just below it.
  assign is_free_slot = (count == CW'(IDX));
  assign is_tail      = (count == CW'(IDX + 1));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_front) begin
      data_nxt = (IDX == 0) ? push_value : from_left;
    end else if (ctrl.push_back && is_free_slot) begin
      data_nxt = push_value;
    end else if (ctrl.pop_front) begin
      data_nxt = from_right;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q    = data_r;
  assign tail_data = is_tail ? data_r : '0;

endmodule
